// ===== hdl/prq_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and state codes of the four-level run queue.
package prq_pkg;

  localparam int SLOT_W  = 10;
  localparam int SLOTS   = 1 << SLOT_W;
  localparam int LEVELS  = 4;
  localparam int LVL_W   = $clog2(LEVELS);
  localparam int STEP_W  = SLOT_W + 1;
  localparam int BG_W    = 8;
  localparam logic [BG_W-1:0] BG_RESET = 8'd8;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [LVL_W-1:0]  lvl_t;
  typedef logic [LEVELS-1:0] mask_t;
  typedef logic [STEP_W-1:0] step_t;
  typedef logic [BG_W-1:0]   bg_t;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_REM  = 2'd1,
    OP_PICK = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PICK_WB,
    ST_REM_LVL,
    ST_REM_HEAD,
    ST_REM_WALK,
    ST_REM_CUR,
    ST_REM_LINK,
    ST_REM_END
  } state_t;

  typedef struct packed {
    logic  we;
    slot_t waddr;
    slot_t wdata;
    logic  re;
    slot_t raddr;
  } mem_req_t;

endpackage

// ===== hdl/prq_if.sv =====
`timescale 1ns / 1ps
// Handshake channels of the run queue: request, result and configuration.
interface prq_in_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               op;
  logic [prq_pkg::SLOT_W-1:0] slot;
  logic [prq_pkg::LVL_W-1:0]  level;
  modport source (output valid, output op, output slot, output level, input ready);
  modport sink   (input valid, input op, input slot, input level, output ready);
endinterface

interface prq_out_if;
  logic                       valid;
  logic                       ready;
  logic [prq_pkg::SLOT_W-1:0] picked_slot;
  logic                       ok;
  logic [prq_pkg::LEVELS-1:0] waiting_mask;
  modport source (output valid, output picked_slot, output ok, output waiting_mask,
                  input ready);
  modport sink   (input valid, input picked_slot, input ok, input waiting_mask,
                  output ready);
endinterface

interface prq_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [prq_pkg::BG_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/four_level_priority_run_queue_core.sv =====
`timescale 1ns / 1ps
// Top level of the four-level priority run queue.
//
//  channel  dir  handshake      payload
//  in_ch    in   valid/ready    op[1:0] slot[9:0] level[1:0]
//  out_ch   out  valid/ready    picked_slot[9:0] ok waiting_mask[3:0]
//  cfg_ch   in   valid/ready    data[7:0] = background ratio, always ready
//
// Enqueue and no-ops finish in the execute state; a pick does too, or goes on to
// a write-back state after a link read when the level holds more than one slot.
// Remove steps through a level state per level, walk and compare states per entry
// walked, a relink or splice state and an end state; one link read port paces it.
// Reset is synchronous and clears heads, tails, mask and counter, not the links.
// A stalled result holds the next item in its last step until the output frees.
module four_level_priority_run_queue_core (
  input  logic      clk,
  input  logic      rst_n,
  prq_in_if.sink    in_ch,
  prq_out_if.source out_ch,
  prq_cfg_if.sink   cfg_ch
);

  prq_pkg::state_t  state_r, state_nxt;
  prq_pkg::op_t     op_r, op_nxt;
  prq_pkg::slot_t   slot_r, slot_nxt;
  prq_pkg::lvl_t    lvl_in_r, lvl_in_nxt;
  prq_pkg::slot_t   head_r [prq_pkg::LEVELS];
  prq_pkg::slot_t   head_nxt [prq_pkg::LEVELS];
  prq_pkg::slot_t   tail_r [prq_pkg::LEVELS];
  prq_pkg::slot_t   tail_nxt [prq_pkg::LEVELS];
  prq_pkg::mask_t   mask_r, mask_nxt;
  prq_pkg::bg_t     bg_cnt_r, bg_cnt_nxt;
  prq_pkg::bg_t     bg_prop_r;
  prq_pkg::lvl_t    q_r, q_nxt;
  prq_pkg::lvl_t    rlvl_r, rlvl_nxt;
  prq_pkg::slot_t   prev_r, prev_nxt;
  prq_pkg::step_t   steps_r, steps_nxt;
  logic             res_ok_r, res_ok_nxt;
  logic             out_valid_r, out_valid_nxt;
  prq_pkg::slot_t   out_slot_r, out_slot_nxt;
  logic             out_ok_r, out_ok_nxt;
  prq_pkg::mask_t   out_mask_r, out_mask_nxt;

  prq_pkg::mem_req_t mem_req;
  prq_pkg::slot_t    mem_rdata;

  logic             in_fire;
  logic             out_free;
  logic             q_any;
  logic             bg_use;
  logic             bg_wrap;
  prq_pkg::bg_t     bg_lim;
  logic [prq_pkg::BG_W:0] bg_inc;
  prq_pkg::lvl_t    q_sel;
  prq_pkg::lvl_t    idx;
  prq_pkg::slot_t   cur_head;
  prq_pkg::slot_t   cur_tail;
  logic             rem_skip;
  logic             rem_last;
  logic             head_hit;
  logic             tail_hit;
  logic             walk_stop;
  logic             cur_hit;

  prq_link_mem u_link_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  assign in_ch.ready  = (state_r == prq_pkg::ST_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.picked_slot  = out_slot_r;
  assign out_ch.ok           = out_ok_r;
  assign out_ch.waiting_mask = out_mask_r;

  // background counter: a zero proportion behaves as one
  assign bg_lim  = (bg_prop_r == '0) ? prq_pkg::BG_W'(1) : bg_prop_r;
  assign bg_inc  = {1'b0, bg_cnt_r} + (prq_pkg::BG_W+1)'(1);
  assign bg_wrap = bg_inc >= {1'b0, bg_lim};
  assign q_any   = |mask_r;
  assign bg_use  = !mask_r[0] && !mask_r[1] && mask_r[3];

  always_comb begin
    priority if (mask_r[0]) begin
      q_sel = prq_pkg::lvl_t'(0);
    end else if (mask_r[1]) begin
      q_sel = prq_pkg::lvl_t'(1);
    end else if (mask_r[2] && mask_r[3]) begin
      q_sel = bg_wrap ? prq_pkg::lvl_t'(3) : prq_pkg::lvl_t'(2);
    end else if (mask_r[2]) begin
      q_sel = prq_pkg::lvl_t'(2);
    end else begin
      q_sel = prq_pkg::lvl_t'(3);
    end
  end

  // one level index per cycle into the head and tail registers
  always_comb begin
    unique case (state_r)
      prq_pkg::ST_EXEC:    idx = (op_r == prq_pkg::OP_ENQ) ? lvl_in_r : q_sel;
      prq_pkg::ST_PICK_WB: idx = q_r;
      default:             idx = rlvl_r;
    endcase
  end

  assign cur_head  = head_r[idx];
  assign cur_tail  = tail_r[idx];
  assign rem_skip  = !mask_r[rlvl_r];
  assign rem_last  = (rlvl_r == prq_pkg::lvl_t'(prq_pkg::LEVELS - 1));
  assign head_hit  = (cur_head == slot_r);
  assign tail_hit  = (cur_tail == slot_r);
  assign walk_stop = (steps_r >= prq_pkg::STEP_W'(prq_pkg::SLOTS)) || (prev_r == cur_tail);
  assign cur_hit   = (mem_rdata == slot_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      prq_pkg::ST_IDLE: begin
        if (in_fire) state_nxt = prq_pkg::ST_EXEC;
      end
      prq_pkg::ST_EXEC: begin
        if (op_r == prq_pkg::OP_REM) begin
          state_nxt = prq_pkg::ST_REM_LVL;
        end else if (out_free) begin
          if (op_r == prq_pkg::OP_PICK && q_any && cur_head != cur_tail) begin
            state_nxt = prq_pkg::ST_PICK_WB;
          end else begin
            state_nxt = prq_pkg::ST_IDLE;
          end
        end
      end
      prq_pkg::ST_PICK_WB: begin
        if (out_free) state_nxt = prq_pkg::ST_IDLE;
      end
      prq_pkg::ST_REM_LVL: begin
        if (rem_skip) begin
          state_nxt = rem_last ? prq_pkg::ST_REM_END : prq_pkg::ST_REM_LVL;
        end else if (head_hit) begin
          state_nxt = tail_hit ? prq_pkg::ST_REM_END : prq_pkg::ST_REM_HEAD;
        end else begin
          state_nxt = prq_pkg::ST_REM_WALK;
        end
      end
      prq_pkg::ST_REM_HEAD: state_nxt = prq_pkg::ST_REM_END;
      prq_pkg::ST_REM_WALK: begin
        if (walk_stop) begin
          state_nxt = rem_last ? prq_pkg::ST_REM_END : prq_pkg::ST_REM_LVL;
        end else begin
          state_nxt = prq_pkg::ST_REM_CUR;
        end
      end
      prq_pkg::ST_REM_CUR: begin
        state_nxt = cur_hit ? prq_pkg::ST_REM_LINK : prq_pkg::ST_REM_WALK;
      end
      prq_pkg::ST_REM_LINK: state_nxt = prq_pkg::ST_REM_END;
      prq_pkg::ST_REM_END: begin
        if (out_free) state_nxt = prq_pkg::ST_IDLE;
      end
      default: state_nxt = prq_pkg::ST_IDLE;
    endcase
  end

  // datapath, memory requests and result register
  always_comb begin
    op_nxt        = op_r;
    slot_nxt      = slot_r;
    lvl_in_nxt    = lvl_in_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    mask_nxt      = mask_r;
    bg_cnt_nxt    = bg_cnt_r;
    q_nxt         = q_r;
    rlvl_nxt      = rlvl_r;
    prev_nxt      = prev_r;
    steps_nxt     = steps_r;
    res_ok_nxt    = res_ok_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_slot_nxt  = out_slot_r;
    out_ok_nxt    = out_ok_r;
    out_mask_nxt  = out_mask_r;
    mem_req       = '0;

    unique case (state_r)
      prq_pkg::ST_IDLE: begin
        if (in_fire) begin
          op_nxt     = prq_pkg::op_t'(in_ch.op);
          slot_nxt   = in_ch.slot;
          lvl_in_nxt = in_ch.level;
        end
      end
      prq_pkg::ST_EXEC: begin
        unique case (op_r)
          prq_pkg::OP_ENQ: begin
            if (out_free) begin
              if (mask_r[lvl_in_r]) begin
                mem_req.we    = 1'b1;
                mem_req.waddr = cur_tail;
                mem_req.wdata = slot_r;
              end else begin
                head_nxt[lvl_in_r] = slot_r;
              end
              tail_nxt[lvl_in_r] = slot_r;
              mask_nxt[lvl_in_r] = 1'b1;
              out_valid_nxt      = 1'b1;
              out_slot_nxt       = '0;
              out_ok_nxt         = 1'b1;
              out_mask_nxt       = mask_nxt;
            end
          end
          prq_pkg::OP_PICK: begin
            if (out_free) begin
              if (q_any) begin
                if (bg_use) bg_cnt_nxt = bg_wrap ? '0 : bg_inc[prq_pkg::BG_W-1:0];
                q_nxt = q_sel;
                if (cur_head == cur_tail) begin
                  mask_nxt[q_sel] = 1'b0;
                  out_valid_nxt   = 1'b1;
                  out_slot_nxt    = cur_head;
                  out_ok_nxt      = 1'b1;
                  out_mask_nxt    = mask_nxt;
                end else begin
                  mem_req.re    = 1'b1;
                  mem_req.raddr = cur_head;
                end
              end else begin
                out_valid_nxt = 1'b1;
                out_slot_nxt  = '0;
                out_ok_nxt    = 1'b0;
                out_mask_nxt  = mask_r;
              end
            end
          end
          prq_pkg::OP_REM: begin
            rlvl_nxt   = '0;
            res_ok_nxt = 1'b0;
          end
          prq_pkg::OP_NOP: begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              out_slot_nxt  = '0;
              out_ok_nxt    = 1'b0;
              out_mask_nxt  = mask_r;
            end
          end
        endcase
      end
      prq_pkg::ST_PICK_WB: begin
        if (out_free) begin
          head_nxt[q_r] = mem_rdata;
          out_valid_nxt = 1'b1;
          out_slot_nxt  = cur_head;
          out_ok_nxt    = 1'b1;
          out_mask_nxt  = mask_r;
        end
      end
      prq_pkg::ST_REM_LVL: begin
        if (rem_skip) begin
          rlvl_nxt = rlvl_r + prq_pkg::lvl_t'(1);
        end else if (head_hit) begin
          if (tail_hit) begin
            mask_nxt[rlvl_r] = 1'b0;
            res_ok_nxt       = 1'b1;
          end else begin
            mem_req.re    = 1'b1;
            mem_req.raddr = slot_r;
          end
        end else begin
          prev_nxt  = cur_head;
          steps_nxt = '0;
        end
      end
      prq_pkg::ST_REM_HEAD: begin
        head_nxt[rlvl_r] = mem_rdata;
        res_ok_nxt       = 1'b1;
      end
      prq_pkg::ST_REM_WALK: begin
        if (walk_stop) begin
          rlvl_nxt = rlvl_r + prq_pkg::lvl_t'(1);
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = prev_r;
        end
      end
      prq_pkg::ST_REM_CUR: begin
        if (cur_hit) begin
          // fetch the successor of the removed slot to splice it out
          mem_req.re    = 1'b1;
          mem_req.raddr = mem_rdata;
          if (mem_rdata == cur_tail) tail_nxt[rlvl_r] = prev_r;
        end else begin
          prev_nxt  = mem_rdata;
          steps_nxt = steps_r + prq_pkg::step_t'(1);
        end
      end
      prq_pkg::ST_REM_LINK: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = prev_r;
        mem_req.wdata = mem_rdata;
        res_ok_nxt    = 1'b1;
      end
      prq_pkg::ST_REM_END: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_slot_nxt  = '0;
          out_ok_nxt    = res_ok_r;
          out_mask_nxt  = mask_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= prq_pkg::ST_IDLE;
      mask_r      <= '0;
      bg_cnt_r    <= '0;
      bg_prop_r   <= prq_pkg::BG_RESET;
      out_valid_r <= 1'b0;
      for (int i = 0; i < prq_pkg::LEVELS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      mask_r      <= mask_nxt;
      bg_cnt_r    <= bg_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      if (cfg_ch.valid && cfg_ch.ready) bg_prop_r <= cfg_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    slot_r     <= slot_nxt;
    lvl_in_r   <= lvl_in_nxt;
    q_r        <= q_nxt;
    rlvl_r     <= rlvl_nxt;
    prev_r     <= prev_nxt;
    steps_r    <= steps_nxt;
    res_ok_r   <= res_ok_nxt;
    out_slot_r <= out_slot_nxt;
    out_ok_r   <= out_ok_nxt;
    out_mask_r <= out_mask_nxt;
  end

endmodule

// ===== hdl/prq_link_mem.sv =====
`timescale 1ns / 1ps
// Next-link table: one write and one registered read port.
module prq_link_mem (
  input  logic               clk,
  input  prq_pkg::mem_req_t  req,
  output prq_pkg::slot_t     rdata
);

  prq_pkg::slot_t mem [prq_pkg::SLOTS];
  prq_pkg::slot_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/prq_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the run queue, bound to the top level.
module prq_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [prq_pkg::SLOT_W-1:0] out_picked_slot,
  input logic                       out_ok,
  input logic [prq_pkg::LEVELS-1:0] out_waiting_mask
);

  // reset leaves the request side open and no result pending
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("queue not idle after reset");

  // a failed step never reports a slot
  a_fail_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_picked_slot == '0)
    else $error("slot reported on a failed step");

  // an accepted item keeps the request side closed while it is worked on
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("new item taken while one is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_picked_slot) &&
      $stable(out_ok) && $stable(out_waiting_mask))
    else $error("stalled result changed");

endmodule

bind four_level_priority_run_queue_core prq_checker u_prq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_picked_slot  (out_ch.picked_slot),
  .out_ok           (out_ch.ok),
  .out_waiting_mask (out_ch.waiting_mask)
);

// ===== tb/sv/four_level_priority_run_queue_checker.sv =====
`timescale 1ns / 1ps
// Run-queue checker: watches the channels, predicts every result and compares it.
module four_level_priority_run_queue_checker
  import prq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        run_over,
  prq_in_if           in_ch,
  prq_out_if          out_ch,
  prq_cfg_if          cfg_ch,
  output int unsigned fail_count
);

  localparam int    LVL_MAX        = 0;
  localparam int    LVL_HIGH       = 1;
  localparam int    LVL_NORMAL     = 2;
  localparam int    LVL_LOW        = 3;
  localparam mask_t ONLY_NORMAL    = mask_t'(1 << LVL_NORMAL);
  localparam mask_t ONLY_LOW       = mask_t'(1 << LVL_LOW);
  localparam mask_t NORMAL_AND_LOW = ONLY_NORMAL | ONLY_LOW;
  localparam int    REPORT_LIMIT   = 10;

  typedef struct packed {
    slot_t picked;
    logic  ok;
    mask_t waiting;
  } run_result_t;

  slot_t       link_tbl [SLOTS];
  slot_t       head_of  [LEVELS];
  slot_t       tail_of  [LEVELS];
  mask_t       busy_levels;
  bg_t         bg_ticks;
  bg_t         bg_ratio;
  run_result_t pending_results [$];
  int unsigned mismatches;
  int unsigned results_checked;
  bit          leftovers_done;

  assign fail_count = mismatches;

  // Advance the background counter; report whether it wrapped.
  task automatic tick_background(output logic wrapped);
    int unsigned lim;
    int unsigned nxt;
    lim = (bg_ratio == '0) ? 1 : bg_ratio;
    nxt = bg_ticks + 1;
    if (nxt >= lim) begin
      bg_ticks = '0;
      wrapped  = 1'b1;
    end else begin
      bg_ticks = bg_t'(nxt);
      wrapped  = 1'b0;
    end
  endtask

  // Unlink a slot from the first level whose list holds it.
  task automatic unlink_slot(input slot_t s, output logic found);
    slot_t prev;
    slot_t cur;
    int    steps;
    found = 1'b0;
    for (int i = 0; i < LEVELS && !found; i++) begin
      if (busy_levels[i]) begin
        if (head_of[i] == s) begin
          if (tail_of[i] == s) busy_levels[i] = 1'b0;
          else head_of[i] = link_tbl[s];
          found = 1'b1;
        end else begin
          prev = head_of[i];
          for (steps = 0; steps < SLOTS && prev != tail_of[i] && !found; steps++) begin
            cur = link_tbl[prev];
            if (cur == s) begin
              link_tbl[prev] = link_tbl[cur];
              if (cur == tail_of[i]) tail_of[i] = prev;
              found = 1'b1;
            end
            prev = cur;
          end
        end
      end
    end
  endtask

  task automatic predict_queue_step(input op_t op, input slot_t s, input lvl_t lv,
                                    output run_result_t res);
    int   q;
    logic wrapped;
    logic found;
    res = '0;
    case (op)
      OP_ENQ: begin
        if (busy_levels[lv]) link_tbl[tail_of[lv]] = s;
        else head_of[lv] = s;
        tail_of[lv]     = s;
        busy_levels[lv] = 1'b1;
        res.ok          = 1'b1;
      end
      OP_REM: begin
        unlink_slot(s, found);
        res.ok = found;
      end
      OP_PICK: begin
        q = LEVELS;
        if (busy_levels[LVL_MAX]) q = LVL_MAX;
        else if (busy_levels[LVL_HIGH]) q = LVL_HIGH;
        else if (busy_levels == ONLY_NORMAL) q = LVL_NORMAL;
        else if (busy_levels == NORMAL_AND_LOW) begin
          // low gets its turn only when the counter wraps
          tick_background(wrapped);
          q = wrapped ? LVL_LOW : LVL_NORMAL;
        end else if (busy_levels == ONLY_LOW) begin
          tick_background(wrapped);
          q = LVL_LOW;
        end
        if (q < LEVELS) begin
          res.picked = head_of[q];
          if (head_of[q] == tail_of[q]) busy_levels[q] = 1'b0;
          else head_of[q] = link_tbl[head_of[q]];
          res.ok = 1'b1;
        end
      end
      default: ;
    endcase
    res.waiting = busy_levels;
  endtask

  task automatic note_mismatch();
    mismatches++;
  endtask

  always @(posedge clk) begin
    run_result_t want;
    run_result_t got;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) link_tbl[i] = '0;
      for (int i = 0; i < LEVELS; i++) begin
        head_of[i] = '0;
        tail_of[i] = '0;
      end
      busy_levels     = '0;
      bg_ticks        = '0;
      bg_ratio        = BG_RESET;
      mismatches      = 0;
      results_checked = 0;
      leftovers_done  = 1'b0;
      pending_results.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) bg_ratio = cfg_ch.data;
      if (in_ch.valid && in_ch.ready) begin
        predict_queue_step(op_t'(in_ch.op), in_ch.slot, in_ch.level, want);
        pending_results.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.picked  = out_ch.picked_slot;
        got.ok      = out_ch.ok;
        got.waiting = out_ch.waiting_mask;
        if (pending_results.size() == 0) begin
          note_mismatch();
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: unexpected result slot %0d ok %0b mask %b", $realtime,
                     got.picked, got.ok, got.waiting);
        end else begin
          want = pending_results.pop_front();
          if (got.picked !== want.picked || got.ok !== want.ok ||
              got.waiting !== want.waiting) begin
            note_mismatch();
            if (mismatches <= REPORT_LIMIT)
              $display({"%0t: result %0d expected slot %0d ok %0b mask %b,",
                        " got slot %0d ok %0b mask %b"},
                       $realtime, results_checked, want.picked, want.ok, want.waiting,
                       got.picked, got.ok, got.waiting);
          end
        end
        results_checked++;
      end
      if (run_over && !leftovers_done) begin
        leftovers_done = 1'b1;
        if (pending_results.size() != 0) begin
          $display("%0d predicted results never arrived", pending_results.size());
          mismatches += pending_results.size();
        end
      end
    end
  end

endmodule

// ===== tb/sv/four_level_priority_run_queue_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench top of the four-level run queue: stimulus, idling and verdict.
module four_level_priority_run_queue_core_tb;
  import prq_pkg::*;

  localparam lvl_t LVL_MAX       = 2'd0;
  localparam lvl_t LVL_HIGH      = 2'd1;
  localparam lvl_t LVL_NORMAL    = 2'd2;
  localparam lvl_t LVL_LOW       = 2'd3;
  localparam int   RANDOM_ITEMS  = 660;
  localparam int   PHASES        = 5;
  localparam int   POOL_DEPTH    = 40;
  localparam int   FILL_SLOTS    = 64;
  localparam int   FIXED_SLOTS   = 10;
  localparam int   SETTLE_CYCLES = 8;
  localparam int   IDLE_PCT      = 15;
  localparam int   TIMEOUT_NS    = 200_000_000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        steady = 1'b0;
  logic        run_over = 1'b0;
  int unsigned fail_count;
  int          items_sent = 0;
  int          results_seen = 0;
  int          op_count [4] = '{0, 0, 0, 0};
  slot_t       pool [$];
  bit          in_pool [SLOTS];
  bit          in_set [SLOTS];
  slot_t       fill_set [FILL_SLOTS];
  slot_t       fixed_slots [FIXED_SLOTS] = '{10'd0, 10'd1023, 10'd341, 10'd682, 10'd512,
                                             10'd100, 10'd200, 10'd300, 10'd9, 10'd10};
  bg_t         ratio_plan [PHASES] = '{8'd1, 8'd255, 8'd0, 8'd2, 8'd5};

  prq_in_if  in_ch ();
  prq_out_if out_ch ();
  prq_cfg_if cfg_ch ();

  four_level_priority_run_queue_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  four_level_priority_run_queue_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .run_over   (run_over),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial out_ch.ready = 1'b0;

  always @(posedge clk) begin
    out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) results_seen <= results_seen + 1;
  end

  // Pick the slots that get enqueued: the directed ones, then distinct random ones.
  task automatic build_fill_set();
    slot_t s;
    for (int k = 0; k < FILL_SLOTS; k++) begin
      if (k < FIXED_SLOTS) begin
        s = fixed_slots[k];
      end else begin
        s = slot_t'($urandom_range(SLOTS - 1));
        while (in_set[s]) s = slot_t'($urandom_range(SLOTS - 1));
      end
      fill_set[k] = s;
      in_set[s]   = 1'b1;
    end
  endtask

  task automatic send_item(input op_t op, input slot_t s, input lvl_t lv);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.slot  <= s;
    in_ch.level <= lv;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    op_count[op]++;
  endtask

  // Drop valid and hold until every item has been answered.
  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    while (results_seen != items_sent) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_ratio(input bg_t value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_item(input bit bg_only);
    int unsigned r;
    int unsigned k;
    slot_t       s;
    lvl_t        lv;
    r  = $urandom_range(99);
    s  = slot_t'($urandom_range(SLOTS - 1));
    lv = bg_only ? lvl_t'($urandom_range(LVL_LOW, LVL_NORMAL))
                 : lvl_t'($urandom_range(LVL_LOW, LVL_MAX));
    if (r < 3 && pool.size() > 0) begin
      // requeue a slot that may still be waiting
      send_item(OP_ENQ, pool[$urandom_range(pool.size() - 1)], lv);
    end else if (r < 40) begin
      s = fill_set[$urandom_range(FILL_SLOTS - 1)];
      while (in_pool[s]) s = fill_set[$urandom_range(FILL_SLOTS - 1)];
      pool.push_back(s);
      in_pool[s] = 1'b1;
      if (pool.size() > POOL_DEPTH) begin
        in_pool[pool[0]] = 1'b0;
        void'(pool.pop_front());
      end
      send_item(OP_ENQ, s, lv);
    end else if (r < 60) begin
      if (pool.size() > 0 && $urandom_range(9) < 8) begin
        k = $urandom_range(pool.size() - 1);
        s = pool[k];
        pool.delete(k);
        in_pool[s] = 1'b0;
      end
      send_item(OP_REM, s, lv);
    end else if (r < 96) begin
      send_item(OP_PICK, s, lv);
    end else begin
      send_item(OP_NOP, s, lv);
    end
  endtask

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.op     = OP_NOP;
    in_ch.slot   = '0;
    in_ch.level  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = BG_RESET;
    ratio_plan[PHASES - 1] = bg_t'($urandom_range(16, 3));
    build_fill_set();
    repeat (11) @(posedge clk);
    rst_n  <= 1'b1;
    steady <= 1'b1;
    @(posedge clk);

    // Write the link entry of every slot in use: chain them on low, requeue the
    // first to close the ring, then take it, which leaves the level empty.
    for (int k = 0; k < FILL_SLOTS; k++) send_item(OP_ENQ, fill_set[k], LVL_LOW);
    send_item(OP_ENQ, fill_set[0], LVL_LOW);
    send_item(OP_PICK, '0, LVL_MAX);
    wait_quiet();
    steady <= 1'b0;

    send_item(OP_PICK, '0, LVL_MAX);
    send_item(OP_REM, slot_t'(5), LVL_MAX);
    send_item(OP_NOP, slot_t'(SLOTS - 1), LVL_LOW);
    send_item(OP_ENQ, slot_t'(0), LVL_MAX);
    send_item(OP_ENQ, slot_t'(SLOTS - 1), LVL_LOW);
    send_item(OP_ENQ, slot_t'(341), LVL_NORMAL);
    send_item(OP_ENQ, slot_t'(682), LVL_NORMAL);
    send_item(OP_ENQ, slot_t'(512), LVL_HIGH);
    send_item(OP_REM, slot_t'(682), LVL_MAX);
    send_item(OP_REM, slot_t'(512), LVL_MAX);
    send_item(OP_REM, slot_t'(777), LVL_MAX);
    send_item(OP_PICK, '0, LVL_MAX);
    send_item(OP_PICK, '0, LVL_MAX);
    send_item(OP_ENQ, slot_t'(100), LVL_NORMAL);
    send_item(OP_ENQ, slot_t'(200), LVL_NORMAL);
    send_item(OP_ENQ, slot_t'(300), LVL_LOW);
    for (int n = 0; n < 5; n++) send_item(OP_PICK, '0, LVL_MAX);
    send_item(OP_ENQ, slot_t'(9), LVL_LOW);
    send_item(OP_ENQ, slot_t'(10), LVL_LOW);
    send_item(OP_REM, slot_t'(9), LVL_MAX);
    send_item(OP_ENQ, slot_t'(10), LVL_LOW);
    send_item(OP_PICK, '0, LVL_MAX);

    for (int p = 0; p < PHASES; p++) begin
      wait_quiet();
      write_ratio(ratio_plan[p]);
      steady <= (p == 3);
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        if (p == 1 && n == RANDOM_ITEMS / (2 * PHASES)) wait_quiet();
        random_item(p % 2 == 0);
      end
    end

    wait_quiet();
    run_over <= 1'b1;
    repeat (2) @(posedge clk);
    $display("Covered %0d items: %0d enqueue, %0d remove, %0d pick, %0d no-op",
             items_sent, op_count[OP_ENQ], op_count[OP_REM], op_count[OP_PICK],
             op_count[OP_NOP]);
    $display("Background ratio run at reset value and %0d written settings, 0 and 255 included",
             PHASES);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
